/* design/scof_pkg.sv */
// ----------------------------------------------------------------------------
// scof_pkg
// shared constants, codes and types of the sparse cell offset block
// ----------------------------------------------------------------------------
package scof_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int MAX_CELLS  = 4096;
  localparam int WORD_BITS  = 32;
  localparam int COORD_BITS = 16;

  localparam int NUM_WORDS  = MAX_CELLS / WORD_BITS;
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int OFS_W      = $clog2(MAX_CELLS);
  localparam int CNT_W      = OFS_W + 1;
  localparam int CARD_W     = COORD_BITS + 1;
  localparam int DIM_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int RANGE_W    = 2 * COORD_BITS;

  localparam int DCNT_W     = 3;
  localparam int CELL_CFG_W = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 32;

  localparam int IN_IDX_LSB   = 0;
  localparam int IN_DATA_LSB  = IN_IDX_LSB + WADDR_W;
  localparam int IN_COORD_LSB = IN_DATA_LSB + WORD_BITS;
  localparam int IN_FIELDS_W  = IN_COORD_LSB + MAX_DIMS * COORD_BITS;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * OFS_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_RANGE = 2'd1,
    STAT_OUTSIDE   = 2'd2,
    STAT_PAST_END  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIM_COUNT  = 3'd0,
    CFG_RANGE_0    = 3'd1,
    CFG_RANGE_1    = 3'd2,
    CFG_RANGE_2    = 3'd3,
    CFG_RANGE_3    = 3'd4,
    CFG_CELL_COUNT = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic             done;
    status_t          status;
    logic [OFS_W-1:0] offset;
  } offs_res_t;

  typedef struct packed {
    logic             done;
    logic [OFS_W-1:0] dense;
    logic             empty;
  } rank_res_t;

endpackage

/* design/scof_offset.sv */
// ----------------------------------------------------------------------------
// scof_offset
// range checks and row-major offset, one dimension per cycle on a shared
// multiply-add
// ----------------------------------------------------------------------------
module scof_offset import scof_pkg::*; (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [MAX_DIMS-1:0][COORD_BITS-1:0]   coord,
  input  logic [MAX_DIMS-1:0][RANGE_W-1:0]      range_cfg,
  input  logic [DCNT_W-1:0]                     dim_count,
  input  logic [CELL_CFG_W-1:0]                 cell_count,
  output offs_res_t                             res
);

  localparam int PROD_W = CNT_W + CARD_W;
  localparam int MAC_W  = PROD_W + 1;
  localparam logic [MAC_W-1:0] SAT_MAX = MAC_W'((2 ** CNT_W) - 1);

  typedef enum logic [2:0] {
    O_IDLE = 3'b001,
    O_RUN  = 3'b010,
    O_FIN  = 3'b100
  } ostate_t;

  ostate_t                            state;
  logic [DCNT_W-1:0]                  dims_eff;
  logic [DIM_W-1:0]                   dims_last;
  logic                               bad_range;
  logic                               bad_coord;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0] norm_in;
  logic [MAX_DIMS-1:0][CARD_W-1:0]    card_in;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0] norm;
  logic [MAX_DIMS-1:0][CARD_W-1:0]    card;
  status_t                            status_r;
  logic [CNT_W-1:0]                   off;
  logic [DIM_W-1:0]                   dcnt;
  logic [DIM_W-1:0]                   last_r;
  logic [PROD_W-1:0]                  prod;
  logic [MAC_W-1:0]                   mac;
  logic [CELL_CFG_W-1:0]              cells_eff;
  logic                               past_end;

  always_comb begin
    if (dim_count == '0) begin
      dims_eff = DCNT_W'(1);
    end else if (dim_count > DCNT_W'(MAX_DIMS)) begin
      dims_eff = DCNT_W'(MAX_DIMS);
    end else begin
      dims_eff = dim_count;
    end
    dims_last = DIM_W'(dims_eff - DCNT_W'(1));
  end

  // per-dimension checks, all lanes side by side
  always_comb begin
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] right;
    logic                  used;
    bad_range = 1'b0;
    bad_coord = 1'b0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      left       = range_cfg[d][COORD_BITS-1:0];
      right      = range_cfg[d][RANGE_W-1:COORD_BITS];
      used       = DCNT_W'(d) < dims_eff;
      bad_range  = bad_range | (used & (right < left));
      bad_coord  = bad_coord | (used & ((coord[d] < left) | (coord[d] > right)));
      norm_in[d] = coord[d] - left;
      card_in[d] = {1'b0, right} - {1'b0, left} + CARD_W'(1);
    end
  end

  always_comb begin
    prod = PROD_W'(off) * PROD_W'(card[dcnt]);
    mac  = MAC_W'(prod) + MAC_W'(norm[dcnt]);
  end

  always_comb begin
    if (cell_count > CELL_CFG_W'(MAX_CELLS)) begin
      cells_eff = CELL_CFG_W'(MAX_CELLS);
    end else begin
      cells_eff = cell_count;
    end
    past_end = CELL_CFG_W'(off) >= cells_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= O_IDLE;
    end else begin
      case (state)
        O_IDLE: begin
          if (start) begin
            norm   <= norm_in;
            card   <= card_in;
            off    <= '0;
            dcnt   <= '0;
            last_r <= dims_last;
            if (bad_range) begin
              status_r <= STAT_BAD_RANGE;
              state    <= O_FIN;
            end else if (bad_coord) begin
              status_r <= STAT_OUTSIDE;
              state    <= O_FIN;
            end else begin
              status_r <= STAT_OK;
              state    <= O_RUN;
            end
          end
        end
        O_RUN: begin
          // running offset saturates; it never shrinks, so a cap still ends past the cells
          off <= (mac > SAT_MAX) ? '1 : mac[CNT_W-1:0];
          if (dcnt == last_r) begin
            state <= O_FIN;
          end else begin
            dcnt <= dcnt + DIM_W'(1);
          end
        end
        O_FIN: begin
          state <= O_IDLE;
        end
        default: begin
          state <= O_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.done   = (state == O_FIN);
    res.status = status_r;
    res.offset = off[OFS_W-1:0];
    if (status_r == STAT_OK && past_end) begin
      res.status = STAT_PAST_END;
    end
  end

endmodule

/* design/scof_rank.sv */
// ----------------------------------------------------------------------------
// scof_rank
// occupancy bitmap memory and rank sweep, one bitmap word read per cycle
// ----------------------------------------------------------------------------
module scof_rank import scof_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [WADDR_W-1:0]   wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic                 start,
  input  logic [OFS_W-1:0]     offset,
  output rank_res_t            res
);

  function automatic logic [BIT_W:0] popcount(input logic [WORD_BITS-1:0] w);
    logic [BIT_W:0] total;
    logic [3:0]     part;
    total = '0;
    for (int b = 0; b < WORD_BITS / 8; b++) begin
      part = '0;
      for (int i = 0; i < 8; i++) begin
        part = part + 4'(w[8*b+i]);
      end
      total = total + (BIT_W+1)'(part);
    end
    return total;
  endfunction

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [WORD_BITS-1:0] rd_data;
  logic [WADDR_W-1:0]   rd_addr;
  logic                 issuing;
  logic                 rd_valid;
  logic                 rd_last;
  logic [WADDR_W-1:0]   widx;
  logic [BIT_W-1:0]     bit_sel;
  logic [OFS_W-1:0]     acc;
  logic [WORD_BITS-1:0] low_mask;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
    end else begin
      rd_valid <= issuing;
      rd_last  <= issuing && (rd_addr == widx);
      if (start) begin
        issuing <= 1'b1;
        rd_addr <= '0;
        widx    <= offset[OFS_W-1:BIT_W];
        bit_sel <= offset[BIT_W-1:0];
        acc     <= '0;
      end else begin
        if (issuing) begin
          if (rd_addr == widx) begin
            issuing <= 1'b0;
          end else begin
            rd_addr <= rd_addr + WADDR_W'(1);
          end
        end
        // whole words below the cell's word
        if (rd_valid && !rd_last) begin
          acc <= acc + OFS_W'(popcount(rd_data));
        end
      end
    end
  end

  assign low_mask = ~({WORD_BITS{1'b1}} << bit_sel);

  always_comb begin
    res.done  = rd_valid && rd_last;
    res.dense = acc + OFS_W'(popcount(rd_data & low_mask));
    res.empty = !rd_data[bit_sel];
  end

endmodule

/* design/sparse_cell_offset.sv */
// ----------------------------------------------------------------------------
// sparse_cell_offset
// row-major cell offset of a chunk with occupancy bitmap rank
//
// channel   group                      word contents (lowest bits first)
// input     s_tvalid/s_tready/s_tdata  word_index, word_data, coord_a..coord_d
//           s_tuser                    action
// output    m_tvalid/m_tready/m_tdata  full_offset, dense_offset, is_empty
//           m_tuser                    status
// config    cfg_we/cfg_index/cfg_data  dim_count, range_0..3, cell_count
//
// a load word writes the bitmap and goes through ST_DONE to the output register
// a query does one multiply-add per dimension, then one bitmap memory read per
// word up to and including the cell's word; a failed range or coordinate check
// skips both, and an offset past the cells skips the memory reads
// one word in flight; s_tready is high only while the core is free
// the output register holds a finished word while the next one is accepted
// synchronous reset clears control and configuration; bitmap is not cleared
// ----------------------------------------------------------------------------
module sparse_cell_offset import scof_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // word_index, word_data, coord_a, coord_b,
                                            // coord_c, coord_d, zero pad
  input  logic                   s_tuser,   // action
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // full_offset, dense_offset, is_empty, zero pad
  output logic [1:0]             m_tuser,   // status
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_OFFS = 4'b0010,
    ST_RANK = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t                              state;
  logic [DCNT_W-1:0]                   dim_count;
  logic [MAX_DIMS-1:0][RANGE_W-1:0]    range_cfg;
  logic [CELL_CFG_W-1:0]               cell_count;
  logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord;
  logic                                in_acc;
  logic                                load;
  logic                                query;
  logic                                out_free;
  logic                                rank_start;
  offs_res_t                           offs_res;
  rank_res_t                           rank_res;
  logic [OFS_W-1:0]                    res_full;
  logic [OFS_W-1:0]                    res_dense;
  logic                                res_empty;
  status_t                             res_status;

  assign s_tready   = (state == ST_IDLE);
  assign in_acc     = s_tvalid && s_tready;
  assign load       = in_acc && (s_tuser == ACT_LOAD);
  assign query      = in_acc && (s_tuser == ACT_QUERY);
  assign coord      = s_tdata[IN_COORD_LSB +: MAX_DIMS*COORD_BITS];
  assign out_free   = !m_tvalid || m_tready;
  assign rank_start = (state == ST_OFFS) && offs_res.done && (offs_res.status == STAT_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count  <= DCNT_W'(1);
      range_cfg  <= '0;
      cell_count <= CELL_CFG_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIM_COUNT:  dim_count    <= cfg_data[DCNT_W-1:0];
        CFG_RANGE_0:    range_cfg[0] <= cfg_data[RANGE_W-1:0];
        CFG_RANGE_1:    range_cfg[1] <= cfg_data[RANGE_W-1:0];
        CFG_RANGE_2:    range_cfg[2] <= cfg_data[RANGE_W-1:0];
        CFG_RANGE_3:    range_cfg[3] <= cfg_data[RANGE_W-1:0];
        CFG_CELL_COUNT: cell_count   <= cfg_data[CELL_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  scof_offset u_offset (
    .clk        (clk),
    .rst        (rst),
    .start      (query),
    .coord      (coord),
    .range_cfg  (range_cfg),
    .dim_count  (dim_count),
    .cell_count (cell_count),
    .res        (offs_res)
  );

  scof_rank u_rank (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (load),
    .wr_addr (s_tdata[IN_IDX_LSB +: WADDR_W]),
    .wr_data (s_tdata[IN_DATA_LSB +: WORD_BITS]),
    .start   (rank_start),
    .offset  (offs_res.offset),
    .res     (rank_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (load) begin
            res_full   <= '0;
            res_dense  <= '0;
            res_empty  <= 1'b0;
            res_status <= STAT_OK;
            state      <= ST_DONE;
          end else if (query) begin
            state <= ST_OFFS;
          end
        end
        ST_OFFS: begin
          if (offs_res.done) begin
            res_status <= offs_res.status;
            res_dense  <= '0;
            res_empty  <= 1'b0;
            if (offs_res.status == STAT_OK) begin
              res_full <= offs_res.offset;
              state    <= ST_RANK;
            end else begin
              res_full <= '0;
              state    <= ST_DONE;
            end
          end
        end
        ST_RANK: begin
          if (rank_res.done) begin
            res_dense <= rank_res.dense;
            res_empty <= rank_res.empty;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
      m_tdata  <= OUT_TDATA_W'({res_empty, res_dense, res_full});
      m_tuser  <= res_status;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_offs_done_waited: assert property (@(posedge clk) disable iff (rst)
    offs_res.done |-> state == ST_OFFS)
    else $error("offset unit finished while control was not waiting for it");

  a_rank_done_waited: assert property (@(posedge clk) disable iff (rst)
    rank_res.done |-> state == ST_RANK)
    else $error("rank sweep finished while control was not waiting for it");

  a_error_word_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != STAT_OK) |-> m_tdata == '0)
    else $error("error status word carries nonzero offsets");

endmodule

/* tb/tb_sparse_cell_offset.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_cell_offset
// self-checking bench for the sparse cell offset block
//
// fills the occupancy bitmap, then runs short directed phases over range,
// dimension count and cell count corners, then random phases. each phase
// sets the registers while the block is idle and streams load and query
// words through it. both stream sides idle at random. every word accepted
// on the input is predicted in the bench and every output word is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_sparse_cell_offset;
  import scof_pkg::*;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          RANDOM_ITEMS   = 950;
  localparam longint unsigned OFFSET_CAP = 64'hFFFF_FFFF;

  typedef struct packed {
    action_t                              action;
    logic [WADDR_W-1:0]                   index;
    logic [WORD_BITS-1:0]                 data;
    logic [MAX_DIMS-1:0][COORD_BITS-1:0]  coord;
  } cell_req_t;

  typedef struct packed {
    logic [OFS_W-1:0] full_offset;
    logic [OFS_W-1:0] dense_offset;
    logic             is_empty;
    status_t          status;
  } cell_ans_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // word_index, word_data, coord_a..coord_d, zero pad
  logic                   s_tuser = 1'b0; // action
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // full_offset, dense_offset, is_empty, zero pad
  logic [1:0]             m_tuser;        // status
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  // bench copy of the block state
  logic [WORD_BITS-1:0]   occupancy [NUM_WORDS];
  logic [DCNT_W-1:0]      dims_reg = 3'd1;
  logic [RANGE_W-1:0]     span_reg [MAX_DIMS] = '{default: '0};
  logic [CELL_CFG_W-1:0]  cells_reg = 13'd1;

  cell_req_t pending_reqs [$];
  cell_ans_t cell_results_due [$];
  cell_req_t cur_req;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   in_gap = 0;
  int   out_wait = 0;
  bit   in_burst = 1'b0;
  bit   out_burst = 1'b0;
  int   fail_count = 0;
  int   quiet_cycles = 0;
  int   random_items = 0;

  sparse_cell_offset dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic cell_ans_t locate_cell(cell_req_t req);
    cell_ans_t       ans;
    int unsigned     ndims;
    longint unsigned cells, off, lo, hi, card, c;
    longint unsigned word, bitpos;
    int unsigned     dense;
    status_t         st;
    ans = '0;
    if (req.action == ACT_LOAD) begin
      occupancy[req.index] = req.data;
      return ans;
    end
    ndims = (dims_reg == 0) ? 1 : ((dims_reg > MAX_DIMS) ? MAX_DIMS : dims_reg);
    cells = (cells_reg > MAX_CELLS) ? MAX_CELLS : cells_reg;
    st = STAT_OK;
    for (int d = 0; d < ndims; d++) begin
      if (span_reg[d][RANGE_W-1:COORD_BITS] < span_reg[d][COORD_BITS-1:0]) st = STAT_BAD_RANGE;
    end
    if (st == STAT_OK) begin
      for (int d = 0; d < ndims; d++) begin
        lo = span_reg[d][COORD_BITS-1:0];
        hi = span_reg[d][RANGE_W-1:COORD_BITS];
        c = req.coord[d];
        if (c < lo || c > hi) st = STAT_OUTSIDE;
      end
    end
    if (st == STAT_OK) begin
      off = 0;
      for (int d = 0; d < ndims; d++) begin
        lo = span_reg[d][COORD_BITS-1:0];
        hi = span_reg[d][RANGE_W-1:COORD_BITS];
        card = hi - lo + 1;
        if (off > 0 && card > OFFSET_CAP / off) off = OFFSET_CAP;
        else off = off * card;
        off += req.coord[d] - lo;
        if (off > OFFSET_CAP) off = OFFSET_CAP;
      end
      if (off >= cells) st = STAT_PAST_END;
    end
    if (st != STAT_OK) begin
      ans.status = st;
      return ans;
    end
    dense = 0;
    for (longint unsigned w = 0; w < off / WORD_BITS; w++) dense += $countones(occupancy[w]);
    word = occupancy[off / WORD_BITS];
    bitpos = off % WORD_BITS;
    dense += $countones(word & ((64'd1 << bitpos) - 1));
    ans.is_empty = !word[bitpos];
    ans.full_offset = off[OFS_W-1:0];
    ans.dense_offset = dense[OFS_W-1:0];
    ans.status = STAT_OK;
    return ans;
  endfunction

  task automatic note_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endtask

  // input side: driver at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        cur_req = pending_reqs.pop_front();
        s_tdata <= IN_TDATA_W'({cur_req.coord, cur_req.data, cur_req.index});
        s_tuser <= cur_req.action;
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 9);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) cell_results_due = {cell_results_due, locate_cell(cur_req)};
  end

  // output side: ready at the falling edge, check at the rising edge
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
        out_wait = out_burst ? 0 : $urandom_range(0, 9);
      end else if (out_wait > 0) begin
        out_wait--;
      end
      m_tready <= (out_wait == 0);
    end
  end

  always @(posedge clk) begin
    cell_ans_t seen, want;
    out_taken <= !rst && m_tvalid && m_tready;
    if (!rst && m_tvalid && m_tready) begin
      seen.full_offset = m_tdata[OFS_W-1:0];
      seen.dense_offset = m_tdata[2*OFS_W-1:OFS_W];
      seen.is_empty = m_tdata[2*OFS_W];
      seen.status = status_t'(m_tuser);
      if (cell_results_due.size() == 0) begin
        note_failure($sformatf("unexpected word: full %0d dense %0d empty %0d status %0d",
                               seen.full_offset, seen.dense_offset, seen.is_empty, seen.status));
      end else begin
        want = cell_results_due.pop_front();
        if (seen.full_offset !== want.full_offset || seen.dense_offset !== want.dense_offset ||
            seen.is_empty !== want.is_empty || seen.status !== want.status)
          note_failure($sformatf(
            "mismatch: full %0d/%0d dense %0d/%0d empty %0d/%0d status %0d/%0d (exp/act)",
            want.full_offset, seen.full_offset, want.dense_offset, seen.dense_offset,
            want.is_empty, seen.is_empty, want.status, seen.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sparse_cell_offset verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void push_load(logic [WADDR_W-1:0] idx, logic [WORD_BITS-1:0] data);
    cell_req_t req;
    req.action = ACT_LOAD;
    req.index = idx;
    req.data = data;
    req.coord = {$urandom, $urandom};
    pending_reqs = {pending_reqs, req};
  endfunction

  function automatic void push_query(int unsigned a, int unsigned b, int unsigned c,
                                     int unsigned d);
    cell_req_t req;
    req.action = ACT_QUERY;
    req.index = WADDR_W'($urandom);
    req.data = $urandom;
    req.coord = {COORD_BITS'(d), COORD_BITS'(c), COORD_BITS'(b), COORD_BITS'(a)};
    pending_reqs = {pending_reqs, req};
  endfunction

  function automatic void push_random_query();
    int unsigned lo, hi, sel;
    int unsigned c [MAX_DIMS];
    for (int d = 0; d < MAX_DIMS; d++) begin
      lo = 32'(span_reg[d][COORD_BITS-1:0]);
      hi = 32'(span_reg[d][RANGE_W-1:COORD_BITS]);
      sel = $urandom_range(0, 39);
      if (hi < lo || sel == 0) c[d] = $urandom_range(0, 65535);
      else if (sel == 1) c[d] = lo;
      else if (sel == 2) c[d] = hi;
      else if (sel == 3) c[d] = (lo - 1) & 32'hFFFF;
      else if (sel == 4) c[d] = (hi + 1) & 32'hFFFF;
      else c[d] = $urandom_range(lo, hi);
    end
    push_query(c[0], c[1], c[2], c[3]);
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DIM_COUNT:  dims_reg = val[DCNT_W-1:0];
      CFG_CELL_COUNT: cells_reg = val[CELL_CFG_W-1:0];
      default:        span_reg[2'(idx - CFG_RANGE_0)] = val;
    endcase
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || cell_results_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_setup();
    int unsigned raw_dims, eff, cap, prod, card, lo, hi, pick, bad, cells;
    logic [RANGE_W-1:0] rng [MAX_DIMS];
    raw_dims = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
    eff = (raw_dims == 0) ? 1 : ((raw_dims > MAX_DIMS) ? MAX_DIMS : raw_dims);
    cap = (eff == 1) ? 4096 : (eff == 2) ? 64 : (eff == 3) ? 16 : 8;
    pick = $urandom_range(0, 19);
    prod = 1;
    for (int d = 0; d < MAX_DIMS; d++) begin
      card = $urandom_range(1, cap);
      lo = $urandom_range(0, 65536 - card);
      hi = lo + card - 1;
      rng[d] = (pick == 0) ? RANGE_W'($urandom) : {hi[15:0], lo[15:0]};
      if (d < eff) prod *= card;
    end
    // one used dimension with its ends swapped
    if (pick == 1) begin
      bad = $urandom_range(0, eff - 1);
      lo = $urandom_range(1, 65535);
      hi = $urandom_range(0, lo - 1);
      rng[bad] = {hi[15:0], lo[15:0]};
    end
    case ($urandom_range(0, 9))
      6:       cells = $urandom_range(1, 8191);
      7:       cells = prod - $urandom_range(0, prod - 1);
      8:       cells = $urandom_range(prod, 8191);
      9:       cells = $urandom_range(0, 1) ? 0 : 8191;
      default: cells = prod;
    endcase
    write_reg(CFG_DIM_COUNT, CFG_W'(raw_dims));
    write_reg(CFG_RANGE_0, rng[0]);
    write_reg(CFG_RANGE_1, rng[1]);
    write_reg(CFG_RANGE_2, rng[2]);
    write_reg(CFG_RANGE_3, rng[3]);
    write_reg(CFG_CELL_COUNT, CFG_W'(cells));
  endtask

  initial begin
    int unsigned burst_len;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // whole bitmap present, so no query ever reads an unwritten word
    for (int i = 0; i < NUM_WORDS; i++) push_load(WADDR_W'(i), '1);
    settle();

    // one dimension spanning the full bitmap
    write_reg(CFG_DIM_COUNT, 1);
    write_reg(CFG_RANGE_0, {16'd4095, 16'd0});
    write_reg(CFG_CELL_COUNT, 4096);
    push_query(0, 0, 0, 0);
    push_query(4095, 0, 0, 0);
    push_query(4096, 0, 0, 0);
    push_query(16'hFFFF, 0, 0, 0);
    push_load(WADDR_W'(NUM_WORDS - 1), '0);
    push_query(4095, 0, 0, 0);
    push_load('0, '0);
    push_query(0, 0, 0, 0);
    push_query(31, 0, 0, 0);
    push_query(32, 0, 0, 0);
    settle();

    // four full-width dimensions, cell count above the bitmap size
    write_reg(CFG_DIM_COUNT, 4);
    for (int d = 0; d < MAX_DIMS; d++) write_reg(cfg_index_t'(CFG_RANGE_0 + d), 32'hFFFF_0000);
    write_reg(CFG_CELL_COUNT, 8191);
    push_query(0, 0, 0, 0);
    push_query(0, 0, 0, 4095);
    push_query(0, 0, 0, 16'hFFFF);
    push_query(0, 0, 1, 0);
    push_query(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    settle();

    // swapped range in the second dimension, zero cells
    write_reg(CFG_DIM_COUNT, 2);
    write_reg(CFG_RANGE_0, {16'd9, 16'd5});
    write_reg(CFG_RANGE_1, {16'd5, 16'd9});
    write_reg(CFG_CELL_COUNT, 0);
    push_query(5, 9, 0, 0);
    push_query(100, 100, 0, 0);
    settle();
    write_reg(CFG_DIM_COUNT, 0);
    push_query(5, 100, 0, 0);
    push_query(4, 100, 0, 0);
    settle();
    write_reg(CFG_CELL_COUNT, 5);
    push_query(9, 100, 0, 0);
    push_query(7, 0, 0, 0);
    settle();
    write_reg(CFG_DIM_COUNT, 7);
    write_reg(CFG_RANGE_2, 0);
    write_reg(CFG_RANGE_3, 0);
    push_query(5, 9, 0, 0);
    settle();
    write_reg(CFG_RANGE_1, {16'd9, 16'd5});
    push_query(5, 9, 0, 0);
    push_query(5, 9, 0, 1);
    settle();

    // random bitmap, then random phases
    for (int i = 0; i < NUM_WORDS; i++) push_load(WADDR_W'(i), $urandom);
    random_items += NUM_WORDS;
    settle();
    while (random_items < RANDOM_ITEMS) begin
      random_setup();
      burst_len = $urandom_range(30, 120);
      for (int i = 0; i < burst_len; i++) begin
        if ($urandom_range(0, 6) == 0) push_load(WADDR_W'($urandom), $urandom);
        else push_random_query();
      end
      random_items += burst_len;
      settle();
    end

    repeat (200) @(posedge clk);
    if (cell_results_due.size() != 0)
      note_failure($sformatf("%0d expected words never arrived", cell_results_due.size()));
    if (fail_count == 0) begin
      $display("sparse_cell_offset verification clean");
    end else begin
      $display("sparse_cell_offset verification failed");
    end
    $finish;
  end

endmodule

/* sparse_cell_offset.f */
design/scof_pkg.sv
design/scof_offset.sv
design/scof_rank.sv
design/sparse_cell_offset.sv
tb/tb_sparse_cell_offset.sv
